@@ src/pws_pkg.sv @@
// Package: shared constants and register indexes of the pulse-wave shaper.
`timescale 1ns / 1ps
`default_nettype none
package pws_pkg;

  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned SAMPLE_W = 22;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DUTY_PERCENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_FREE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_EDGES = 2'd2;

  localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;
  localparam logic [DUTY_W-1:0] DUTY_MIN   = 7'd1;
  localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd99;
  localparam logic [DUTY_W-1:0] DUTY_HALF  = 7'd50;
  localparam logic [DUTY_W-1:0] PERCENT    = 7'd100;

  localparam logic [31:0] SAMPLE_POS_MAX = 32'd2097151;
  localparam logic [31:0] SAMPLE_NEG_MAG = 32'd2097152;

  localparam int unsigned LEVEL_NUM = 2500;

endpackage
`default_nettype wire

@@ src/pulse_wave_shaper_unit.sv @@
// Top level: pipelined pulse-wave shaper with level divider and config registers.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------
//  in      | in        | in_valid_i / in_stall_o | phase_i [PHASE_BITS]
//  out     | out       | out_valid_o/out_stall_i | sample_o [22] signed
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  One phase enters per cycle while in_stall_o is low (divider idle, pipeline
//  not stalled); the depth is set by the one-bit-per-stage division that forms the smoothstep argument.
//  After reset and after each config transaction the level divider computes
//  both levels in turn, and in_stall_o is high while it runs.
//  Every stage holds while the stage after it is full and stalled.
`timescale 1ns / 1ps
`default_nettype none
module pulse_wave_shaper_unit
  import pws_pkg::*;
#(
  parameter int unsigned PHASE_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [PHASE_BITS-1:0] phase_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [SAMPLE_W-1:0]        sample_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [DUTY_W-1:0]     cfg_data_i
);

  localparam int unsigned PB   = PHASE_BITS;
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned NW   = PB + 9;
  localparam int unsigned RW   = F + 9;
  localparam int unsigned NDIV = F + 1;
  localparam int unsigned LW   = F + 5;
  localparam int unsigned SQ   = NDIV + 1;
  localparam int unsigned SS   = NDIV + 2;
  localparam int unsigned SM   = NDIV + 3;
  localparam int unsigned SO   = NDIV + 4;
  localparam int unsigned NS   = NDIV + 5;
  localparam int unsigned DW   = 14;
  localparam int unsigned NUMW = F + 13;
  localparam int unsigned CW   = $clog2(NUMW + 1);
  localparam logic [LW-1:0]  ONE_L     = LW'(1) << F;
  localparam logic [F+2:0]   THREE_ONE = (F + 3)'(3) << F;
  localparam logic [NUMW-1:0] LVL_NUM  = NUMW'(LEVEL_NUM) << F;

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV} lvl_state_e;

  // configuration
  logic [DUTY_W-1:0] duty_q;
  logic              offset_free_q, smooth_q;
  logic              cfg_we;
  logic [DUTY_W-1:0] p, q;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q        <= DUTY_RESET;
      offset_free_q <= 1'b1;
      smooth_q      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_DUTY_PERCENT: duty_q        <= cfg_data_i;
        REG_OFFSET_FREE:  offset_free_q <= cfg_data_i[0];
        REG_SMOOTH_EDGES: smooth_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    p = duty_q;
    if (duty_q < DUTY_MIN) p = DUTY_MIN;
    if (duty_q > DUTY_MAX) p = DUTY_MAX;
    q = PERCENT - p;
  end

  // level divider: round(2500 * 2^F / den) for both levels
  lvl_state_e     state_q;
  logic           sel_q;
  logic [NUMW-1:0] num_q;
  logic [DW-1:0]  rem_lv_q, den_q, den;
  logic [CW-1:0]  cnt_q;
  logic [LW-1:0]  quo_q, amag_q, bmag_q, quo_next;
  logic [DW:0]    rem_sh;
  logic           lv_cmp;

  always_comb begin
    if (p < DUTY_HALF) begin
      den = sel_q ? DW'(q) * DW'(q) : DW'(p) * DW'(q);
    end else begin
      den = sel_q ? DW'(p) * DW'(q) : DW'(p) * DW'(p);
    end
    rem_sh   = {rem_lv_q, num_q[NUMW-1]};
    lv_cmp   = rem_sh >= {1'b0, den_q};
    quo_next = {quo_q[LW-2:0], lv_cmp};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      sel_q   <= 1'b0;
      cnt_q   <= '0;
    end else if (cfg_we) begin
      state_q <= ST_LOAD;
      sel_q   <= 1'b0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          num_q    <= LVL_NUM + NUMW'(den >> 1);
          den_q    <= den;
          rem_lv_q <= '0;
          quo_q    <= '0;
          cnt_q    <= '0;
          state_q  <= ST_DIV;
        end
        ST_DIV: begin
          rem_lv_q <= lv_cmp ? DW'(rem_sh - {1'b0, den_q}) : DW'(rem_sh);
          quo_q    <= quo_next;
          num_q    <= num_q << 1;
          cnt_q    <= cnt_q + 1'b1;
          if (cnt_q == CW'(NUMW - 1)) begin
            if (!sel_q) begin
              amag_q  <= quo_next;
              sel_q   <= 1'b1;
              state_q <= ST_LOAD;
            end else begin
              bmag_q  <= quo_next;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // pipeline control
  logic [NS-1:0] v_q, en;
  logic          busy, in_take;

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    en[NS-1] = !v_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_take    = in_valid_i && !busy;
  assign in_stall_o = busy || !en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_take;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: segment select and scaled numerator
  logic [NW-1:0]   xw, pn, x100, x200, num;
  logic [NW+F-1:0] sh;
  logic [RW-1:0]   r;
  logic            hi;

  always_comb begin
    xw   = NW'(phase_i);
    pn   = NW'(p) << PB;
    x100 = xw * NW'(100);
    x200 = xw * NW'(200);
    hi   = x100 < pn;
    if (hi) begin
      num = (x200 < pn) ? x200 : (pn << 1) - x200;
    end else if (x200 < ((NW'(PERCENT) + NW'(p)) << PB)) begin
      num = x200 - (pn << 1);
    end else begin
      num = ((NW'(1) << PB) - xw) * NW'(200);
    end
    sh = {num, {F{1'b0}}} >> PB;
    r  = sh[RW-1:0];
  end

  logic [DUTY_W-1:0] rem_q [NDIV+1];
  logic [F:0]        rlo_q [NDIV+1];
  logic [F:0]        qt_q  [NDIV+1];
  logic              hi_q  [NDIV+1];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rem_q[0] <= r[F+7:F+1];
      rlo_q[0] <= r[F:0];
      qt_q[0]  <= '0;
      hi_q[0]  <= hi;
    end
  end

  // stages 1..NDIV: one quotient bit each
  for (genvar j = 1; j <= NDIV; j++) begin : g_div
    logic [DUTY_W:0]   trial;
    logic [DUTY_W-1:0] d;
    logic              take;
    assign d     = hi_q[j-1] ? p : q;
    assign trial = {rem_q[j-1], rlo_q[j-1][NDIV-j]};
    assign take  = trial >= {1'b0, d};
    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        rem_q[j] <= take ? DUTY_W'(trial - {1'b0, d}) : DUTY_W'(trial);
        rlo_q[j] <= rlo_q[j-1];
        qt_q[j]  <= {qt_q[j-1][F-1:0], take};
        hi_q[j]  <= hi_q[j-1];
      end
    end
  end

  // smoothstep and level
  logic [F:0]     t_q, t2_q, s_q;
  logic           hi_sq_q, hi_ss_q, neg_q;
  logic [2*F+1:0] tt;
  logic [F+2:0]   w;
  logic [2*F+3:0] sp;
  logic [LW-1:0]  lvl, mag_q;
  logic [2*F+5:0] mp;

  assign tt  = (2 * F + 2)'(qt_q[NDIV]) * (2 * F + 2)'(qt_q[NDIV]);
  assign w   = THREE_ONE - (F + 3)'({t_q, 1'b0});
  assign sp  = (2 * F + 4)'(t2_q) * (2 * F + 4)'(w);
  assign lvl = !offset_free_q ? ONE_L : (hi_ss_q ? amag_q : bmag_q);
  assign mp  = (2 * F + 6)'(lvl) * (2 * F + 6)'(s_q);

  always_ff @(posedge clk_i) begin
    if (en[SQ]) begin
      t_q     <= qt_q[NDIV];
      t2_q    <= tt[2*F:F];
      hi_sq_q <= hi_q[NDIV];
    end
    if (en[SS]) begin
      s_q     <= sp[2*F:F];
      hi_ss_q <= hi_sq_q;
    end
    if (en[SM]) begin
      mag_q <= smooth_q ? mp[2*F+4:F] : lvl;
      neg_q <= !hi_ss_q;
    end
  end

  // saturate to the output range
  logic [31:0]         magx;
  logic [SAMPLE_W-1:0] sample_d, sample_q;

  always_comb begin
    magx = 32'(mag_q);
    if (neg_q) begin
      sample_d = (magx > SAMPLE_NEG_MAG) ? SAMPLE_W'(0 - SAMPLE_NEG_MAG)
                                          : SAMPLE_W'(0 - magx);
    end else begin
      sample_d = (magx > SAMPLE_POS_MAX) ? SAMPLE_W'(SAMPLE_POS_MAX)
                                          : SAMPLE_W'(magx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[SO]) sample_q <= sample_d;
  end

  assign out_valid_o = v_q[NS-1];
  assign sample_o    = sample_q;

endmodule
`default_nettype wire

@@ src/pws_checker.sv @@
// Checker: port-level properties of the pulse-wave shaper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pws_checker
  import pws_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [SAMPLE_W-1:0]  sample_o,
  input wire logic                 cfg_valid_i,
  input wire logic                 cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_o))
    else $error("stalled output transaction changed");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> in_stall_o)
    else $error("input taken while levels recompute");

  a_cfg_busy2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> ##1 in_stall_o)
    else $error("input taken during level division");

  a_reset_busy: assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> in_stall_o)
    else $error("input taken before levels are ready");

endmodule

bind pulse_wave_shaper_unit pws_checker u_pws_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .sample_o    (sample_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
`default_nettype wire
